>>> hdl/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types, codes and constants of the stroke Bezier smoother.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int COORD_W    = 16;
   localparam int WIDTH_W    = 12;
   localparam int PEN_W      = 8;
   localparam int WIDTH_FRAC = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // shared unit widths
   localparam int MUL_W     = 18;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = 35;
   localparam int QUO_BITS  = 17;
   localparam int SQRT_TOP  = 32;
   localparam int STEP_CNT_W = 5;
   localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(QUO_BITS - 1);

   localparam int DEF_MIN_SEGMENTS   = 32;
   localparam int DEF_MAX_SEGMENTS   = 63;
   localparam int DEF_SEGMENT_LENGTH = 2;
   localparam int DEF_FRAC_BITS      = 4;

   localparam logic [1:0] EV_BEGIN  = 2'd0;
   localparam logic [1:0] EV_MOVE   = 2'd1;
   localparam logic [1:0] EV_END    = 2'd2;
   localparam logic [1:0] EV_UNUSED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RECT_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_BOTTOM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_RIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_TOP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEN_WIDTH   = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [WIDTH_W-1:0] out_width;
      logic               last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ALU_IDLE,
      ALU_ACC_LOAD,
      ALU_ACC_ADD,
      ALU_ACC_ADDB,
      ALU_DIV_INIT,
      ALU_SQRT_INIT,
      ALU_DIV_STEP,
      ALU_SQRT_STEP
   } alu_op_type;

   typedef struct packed {
      logic             mul_en;
      alu_op_type       op;
      logic [MUL_W-1:0] opa;
      logic [MUL_W-1:0] opb;
      logic [MUL_W-1:0] den;
   } alu_ctrl_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic [ACC_W-1:0]  acc;
      logic [ACC_W-1:0]  quo;
   } alu_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_APPEND,
      S_TX,
      S_TY,
      S_TADD,
      S_TCMP,
      S_DX,
      S_DY,
      S_DADD,
      S_SQI,
      S_SQS,
      S_KQ,
      S_NSET,
      S_NN,
      S_NNW,
      S_CU,
      S_CM,
      S_CJ,
      S_CJW,
      S_B0,
      S_B1,
      S_B2,
      S_B3,
      S_B4,
      S_BDI,
      S_BDS,
      S_BST,
      S_WAIT
   } seq_state_type;

endpackage

>>> hdl/sbs_alu.sv
// ----------------------------------------------------------------------------
// sbs_alu
// Shared arithmetic unit: registered multiplier, accumulator and one
// compare-subtract stage used for restoring division and integer square root.
// ----------------------------------------------------------------------------
module sbs_alu (
   input  logic                  clock,
   input  sbs_pkg::alu_ctrl_type ctrl,
   output sbs_pkg::alu_stat_type stat
);
   import sbs_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [ACC_W-1:0]  quo_ff, quo_in;
   logic [ACC_W-1:0]  dsh_ff, dsh_in;
   logic [ACC_W-1:0]  trial;
   logic              ge;

   // sqrt compares against root + bit, division against the shifted divisor
   assign trial = (ctrl.op == ALU_SQRT_STEP) ? (quo_ff + dsh_ff) : dsh_ff;
   assign ge    = (rem_ff >= trial);

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsh_in  = dsh_ff;
      if (ctrl.mul_en) begin
         prod_in = PROD_W'(ctrl.opa) * PROD_W'(ctrl.opb);
      end
      case (ctrl.op)
         ALU_ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ALU_ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         ALU_ACC_ADDB: acc_in = acc_ff + ACC_W'(ctrl.opb);
         ALU_DIV_INIT: begin
            rem_in = acc_ff;
            quo_in = '0;
            dsh_in = ACC_W'(ctrl.den) << (QUO_BITS - 1);
         end
         ALU_SQRT_INIT: begin
            rem_in = acc_ff;
            quo_in = '0;
            dsh_in = ACC_W'(1) << SQRT_TOP;
         end
         ALU_DIV_STEP: begin
            if (ge) begin
               rem_in = rem_ff - trial;
            end
            quo_in = {quo_ff[ACC_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
         end
         ALU_SQRT_STEP: begin
            if (ge) begin
               rem_in = rem_ff - trial;
               quo_in = (quo_ff >> 1) + dsh_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            dsh_in = dsh_ff >> 2;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsh_ff  <= dsh_in;
   end

   assign stat.prod = prod_ff;
   assign stat.acc  = acc_ff;
   assign stat.quo  = quo_ff;

endmodule

>>> hdl/stroke_bezier_smoother.sv
// ----------------------------------------------------------------------------
// stroke_bezier_smoother
// Touch events in, quadratic Bezier stroke points out, computed by a
// sequencer around one shared multiply / divide / square-root unit.
// ----------------------------------------------------------------------------
//   channel   ports                          direction
//   request   req_valid req_stall req_data   in  (event kind, x, y)
//   response  rsp_valid rsp_stall rsp_data   out (x, y, width, last)
//   csr       csr_wr_en csr_index csr_wdata  in  (write only)
//
// An event that closes a triple computes length, square root and segment
// count, then each point with three 17-step divisions, n points plus the
// closing midpoint.
// Reset is synchronous; it clears the history and loads the register defaults.
// A stalled response holds the sequencer until the transfer.
// ----------------------------------------------------------------------------
module stroke_bezier_smoother #(
   parameter int MIN_SEGMENTS   = sbs_pkg::DEF_MIN_SEGMENTS,
   parameter int MAX_SEGMENTS   = sbs_pkg::DEF_MAX_SEGMENTS,
   parameter int SEGMENT_LENGTH = sbs_pkg::DEF_SEGMENT_LENGTH,
   parameter int FRAC_BITS      = sbs_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sbs_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sbs_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_wr_en,
   input  logic [sbs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sbs_pkg::*;

   localparam int NB = $clog2(MAX_SEGMENTS + 1);
   localparam logic [ACC_W-1:0] NEAR_LIMIT = ACC_W'(9) << (2 * FRAC_BITS - 2);
   // root / SEG_DIV as a reciprocal multiply, exact for roots below 2^QUO_BITS
   localparam int SEG_DIV = SEGMENT_LENGTH << (FRAC_BITS + 1);
   localparam int K_SHIFT = QUO_BITS + $clog2(SEG_DIV);
   localparam logic [MUL_W-1:0] K_RECIP =
      MUL_W'(((1 << K_SHIFT) + SEG_DIV - 1) / SEG_DIV);

   seq_state_type state_ff, state_in;

   logic [COORD_W-1:0] rect_left_ff, rect_bottom_ff, rect_right_ff, rect_top_ff;
   logic [PEN_W-1:0]   pen_width_ff;

   logic [1:0]         held_ff, held_in;
   logic [COORD_W-1:0] older_x_ff, older_x_in, older_y_ff, older_y_in;
   logic [COORD_W-1:0] newer_x_ff, newer_x_in, newer_y_ff, newer_y_in;
   logic [WIDTH_W-1:0] older_w_ff, older_w_in, newer_w_ff, newer_w_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [WIDTH_W-1:0] cur_w_ff, cur_w_in;

   logic [NB-1:0]         n_ff, n_in, j_ff, j_in;
   logic [1:0]            chan_ff, chan_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_W-1:0]      cu_ff, cu_in, cm_ff, cm_in, cj_ff, cj_in;
   logic [MUL_W-1:0]      nn_ff, nn_in, den_ff, den_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   alu_ctrl_type alu_ctrl;
   alu_stat_type alu_stat;

   logic               req_fire, rsp_xfer, in_rect, cnt_done, j_last;
   logic [NB-1:0]      u_val;
   logic [COORD_W-1:0] dxn, dyn, dxo, dyo;
   logic [COORD_W-1:0] a_sel, b_sel, c_sel;
   logic [ACC_W-1:0]   k_raw, k_low, k_clamp;
   logic [NB-1:0]      n_new;
   logic [WIDTH_W-1:0] pen_fixed;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                   input logic [COORD_W-1:0] q);
      abs_diff = (p > q) ? (p - q) : (q - p);
   endfunction

   sbs_alu u_alu (
      .clock (clock),
      .ctrl  (alu_ctrl),
      .stat  (alu_stat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_rect = (req_data.req_type != EV_UNUSED) &&
                    (req_data.pos_x >= rect_left_ff) && (req_data.pos_x <= rect_right_ff) &&
                    (req_data.pos_y >= rect_bottom_ff) && (req_data.pos_y <= rect_top_ff);
   assign pen_fixed = {pen_width_ff, WIDTH_FRAC'(0)};

   assign cnt_done = (cnt_ff == STEP_LAST);
   assign j_last   = (j_ff == n_ff - NB'(1));
   assign u_val    = n_ff - j_ff;

   assign dxn = abs_diff(cur_x_ff, newer_x_ff);
   assign dyn = abs_diff(cur_y_ff, newer_y_ff);
   assign dxo = abs_diff(cur_x_ff, older_x_ff);
   assign dyo = abs_diff(cur_y_ff, older_y_ff);

   // segment count: clamp(k) to MIN..MAX, never zero
   assign k_raw   = ACC_W'(alu_stat.prod >> K_SHIFT);
   assign k_low   = (k_raw > ACC_W'(MIN_SEGMENTS)) ? k_raw : ACC_W'(MIN_SEGMENTS);
   assign k_clamp = (k_low > ACC_W'(MAX_SEGMENTS)) ? ACC_W'(MAX_SEGMENTS) : k_low;
   assign n_new   = (k_clamp[NB-1:0] == '0) ? NB'(1) : k_clamp[NB-1:0];

   always_comb begin
      case (chan_ff)
         2'd0: begin
            a_sel = older_x_ff;
            b_sel = newer_x_ff;
            c_sel = cur_x_ff;
         end
         2'd1: begin
            a_sel = older_y_ff;
            b_sel = newer_y_ff;
            c_sel = cur_y_ff;
         end
         default: begin
            a_sel = COORD_W'(older_w_ff);
            b_sel = COORD_W'(newer_w_ff);
            c_sel = COORD_W'(cur_w_ff);
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && in_rect) begin
               if (req_data.req_type == EV_BEGIN) begin
                  state_in = S_DX;
               end else if (req_data.req_type == EV_MOVE && held_ff != 2'd0) begin
                  state_in = S_TX;
               end else begin
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: state_in = (held_ff == 2'd2) ? S_DX : S_IDLE;
         S_TX:     state_in = S_TY;
         S_TY:     state_in = S_TADD;
         S_TADD:   state_in = S_TCMP;
         S_TCMP:   state_in = (alu_stat.acc < NEAR_LIMIT) ? S_IDLE : S_APPEND;
         S_DX:     state_in = S_DY;
         S_DY:     state_in = S_DADD;
         S_DADD:   state_in = S_SQI;
         S_SQI:    state_in = S_SQS;
         S_SQS:    state_in = cnt_done ? S_KQ : S_SQS;
         S_KQ:     state_in = S_NSET;
         S_NSET:   state_in = S_NN;
         S_NN:     state_in = S_NNW;
         S_NNW:    state_in = S_CU;
         S_CU:     state_in = S_CM;
         S_CM:     state_in = S_CJ;
         S_CJ:     state_in = S_CJW;
         S_CJW:    state_in = S_B0;
         S_B0:     state_in = S_B1;
         S_B1:     state_in = S_B2;
         S_B2:     state_in = S_B3;
         S_B3:     state_in = S_B4;
         S_B4:     state_in = S_BDI;
         S_BDI:    state_in = S_BDS;
         S_BDS:    state_in = cnt_done ? S_BST : S_BDS;
         S_BST:    state_in = (chan_ff == 2'd2) ? S_WAIT : S_B0;
         S_WAIT: begin
            if (rsp_xfer) begin
               if (rsp_data_ff.last) begin
                  state_in = S_IDLE;
               end else if (!j_last) begin
                  state_in = S_CU;
               end
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      held_in      = held_ff;
      older_x_in   = older_x_ff;
      older_y_in   = older_y_ff;
      older_w_in   = older_w_ff;
      newer_x_in   = newer_x_ff;
      newer_y_in   = newer_y_ff;
      newer_w_in   = newer_w_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_w_in     = cur_w_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      chan_in      = chan_ff;
      cnt_in       = cnt_ff;
      cu_in        = cu_ff;
      cm_in        = cm_ff;
      cj_in        = cj_ff;
      nn_in        = nn_ff;
      den_in       = den_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      alu_ctrl.mul_en = 1'b0;
      alu_ctrl.op     = ALU_IDLE;
      alu_ctrl.opa    = '0;
      alu_ctrl.opb    = '0;
      alu_ctrl.den    = den_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && in_rect) begin
               cur_x_in = req_data.pos_x;
               cur_y_in = req_data.pos_y;
               cur_w_in = pen_fixed;
               if (req_data.req_type == EV_BEGIN) begin
                  // begin fills the history with the point itself
                  held_in    = 2'd2;
                  older_x_in = req_data.pos_x;
                  older_y_in = req_data.pos_y;
                  older_w_in = pen_fixed;
                  newer_x_in = req_data.pos_x;
                  newer_y_in = req_data.pos_y;
                  newer_w_in = pen_fixed;
               end
            end
         end
         S_APPEND: begin
            if (held_ff != 2'd2) begin
               held_in    = held_ff + 2'd1;
               older_x_in = newer_x_ff;
               older_y_in = newer_y_ff;
               older_w_in = newer_w_ff;
               newer_x_in = cur_x_ff;
               newer_y_in = cur_y_ff;
               newer_w_in = cur_w_ff;
            end
         end
         S_TX: begin
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(dxn);
            alu_ctrl.opb    = MUL_W'(dxn);
         end
         S_TY: begin
            alu_ctrl.op     = ALU_ACC_LOAD;
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(dyn);
            alu_ctrl.opb    = MUL_W'(dyn);
         end
         S_TADD: alu_ctrl.op = ALU_ACC_ADD;
         S_DX: begin
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(dxo);
            alu_ctrl.opb    = MUL_W'(dxo);
         end
         S_DY: begin
            alu_ctrl.op     = ALU_ACC_LOAD;
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(dyo);
            alu_ctrl.opb    = MUL_W'(dyo);
         end
         S_DADD: alu_ctrl.op = ALU_ACC_ADD;
         S_SQI: begin
            alu_ctrl.op = ALU_SQRT_INIT;
            cnt_in      = '0;
         end
         S_SQS: begin
            alu_ctrl.op = ALU_SQRT_STEP;
            cnt_in      = cnt_ff + STEP_CNT_W'(1);
         end
         S_KQ: begin
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(alu_stat.quo);
            alu_ctrl.opb    = K_RECIP;
         end
         S_NSET: begin
            n_in = n_new;
            j_in = '0;
         end
         S_NN: begin
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(n_ff);
            alu_ctrl.opb    = MUL_W'(n_ff);
         end
         S_NNW: begin
            nn_in  = MUL_W'(alu_stat.prod);
            den_in = MUL_W'(alu_stat.prod << 1);
         end
         S_CU: begin
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(u_val);
            alu_ctrl.opb    = MUL_W'(u_val);
         end
         S_CM: begin
            cu_in           = MUL_W'(alu_stat.prod);
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(u_val);
            alu_ctrl.opb    = MUL_W'(j_ff);
         end
         S_CJ: begin
            cm_in           = MUL_W'(alu_stat.prod << 2);
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = MUL_W'(j_ff);
            alu_ctrl.opb    = MUL_W'(j_ff);
         end
         S_CJW: begin
            cj_in   = MUL_W'(alu_stat.prod);
            chan_in = 2'd0;
         end
         S_B0: begin
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = cu_ff;
            alu_ctrl.opb    = MUL_W'(a_sel) + MUL_W'(b_sel);
         end
         S_B1: begin
            alu_ctrl.op     = ALU_ACC_LOAD;
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = cm_ff;
            alu_ctrl.opb    = MUL_W'(b_sel);
         end
         S_B2: begin
            alu_ctrl.op     = ALU_ACC_ADD;
            alu_ctrl.mul_en = 1'b1;
            alu_ctrl.opa    = cj_ff;
            alu_ctrl.opb    = MUL_W'(b_sel) + MUL_W'(c_sel);
         end
         S_B3: alu_ctrl.op = ALU_ACC_ADD;
         S_B4: begin
            // + n^2 gives round half up after the divide by 2n^2
            alu_ctrl.op  = ALU_ACC_ADDB;
            alu_ctrl.opb = nn_ff;
         end
         S_BDI: begin
            alu_ctrl.op = ALU_DIV_INIT;
            cnt_in      = '0;
         end
         S_BDS: begin
            alu_ctrl.op = ALU_DIV_STEP;
            cnt_in      = cnt_ff + STEP_CNT_W'(1);
         end
         S_BST: begin
            case (chan_ff)
               2'd0:    rsp_data_in.out_x     = alu_stat.quo[COORD_W-1:0];
               2'd1:    rsp_data_in.out_y     = alu_stat.quo[COORD_W-1:0];
               default: rsp_data_in.out_width = alu_stat.quo[WIDTH_W-1:0];
            endcase
            if (chan_ff == 2'd2) begin
               rsp_data_in.last = 1'b0;
               rsp_valid_in     = 1'b1;
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
         S_WAIT: begin
            if (rsp_xfer) begin
               if (rsp_data_ff.last) begin
                  rsp_valid_in = 1'b0;
                  older_x_in   = newer_x_ff;
                  older_y_in   = newer_y_ff;
                  older_w_in   = newer_w_ff;
                  newer_x_in   = cur_x_ff;
                  newer_y_in   = cur_y_ff;
                  newer_w_in   = cur_w_ff;
               end else if (j_last) begin
                  // closing midpoint of newer and current
                  rsp_data_in.out_x = COORD_W'((({1'b0, newer_x_ff} + {1'b0, cur_x_ff})
                                               + 17'd1) >> 1);
                  rsp_data_in.out_y = COORD_W'((({1'b0, newer_y_ff} + {1'b0, cur_y_ff})
                                               + 17'd1) >> 1);
                  rsp_data_in.out_width = WIDTH_W'((({1'b0, newer_w_ff} + {1'b0, cur_w_ff})
                                                   + 13'd1) >> 1);
                  rsp_data_in.last = 1'b1;
               end else begin
                  rsp_valid_in = 1'b0;
                  j_in         = j_ff + NB'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         held_ff        <= 2'd0;
         older_x_ff     <= '0;
         older_y_ff     <= '0;
         older_w_ff     <= '0;
         newer_x_ff     <= '0;
         newer_y_ff     <= '0;
         newer_w_ff     <= '0;
         rect_left_ff   <= '0;
         rect_bottom_ff <= '0;
         rect_right_ff  <= '1;
         rect_top_ff    <= '1;
         pen_width_ff   <= PEN_W'(5);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         older_x_ff   <= older_x_in;
         older_y_ff   <= older_y_in;
         older_w_ff   <= older_w_in;
         newer_x_ff   <= newer_x_in;
         newer_y_ff   <= newer_y_in;
         newer_w_ff   <= newer_w_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RECT_LEFT:   rect_left_ff   <= csr_wdata;
               CSR_RECT_BOTTOM: rect_bottom_ff <= csr_wdata;
               CSR_RECT_RIGHT:  rect_right_ff  <= csr_wdata;
               CSR_RECT_TOP:    rect_top_ff    <= csr_wdata;
               CSR_PEN_WIDTH:   pen_width_ff   <= csr_wdata[PEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_w_ff    <= cur_w_in;
      n_ff        <= n_in;
      j_ff        <= j_in;
      chan_ff     <= chan_in;
      cnt_ff      <= cnt_in;
      cu_ff       <= cu_in;
      cm_ff       <= cm_in;
      cj_ff       <= cj_in;
      nn_ff       <= nn_in;
      den_ff      <= den_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
